// ===== hdl/kefs_pkg.sv =====
// Package for the Kruskal edge filter with stations.
// Holds node and cost widths, the forest entry layout and the control handoff type.
// No dependencies.
`timescale 1ns / 1ps

package kefs_pkg;

    // Forest size and derived widths
    localparam int NODES  = 2048;
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SIZE_W = $clog2(NODES) + 1;

    // Fixed field widths of the streams
    localparam int IDX_W      = 11;
    localparam int COST_W     = 40;
    localparam int TOTAL_W    = 52;
    localparam int IN_DATA_W  = 64;   // node_a, node_b, cost = 62 bits, padded
    localparam int OUT_DATA_W = 56;   // accepted, running_total = 53 bits, padded

    // Item kinds
    localparam logic KIND_STATION = 1'b0;
    localparam logic KIND_LINK    = 1'b1;

    // One forest entry; size and station only matter at a root
    typedef struct packed {
        logic              station;
        logic [SIZE_W-1:0] size;
        logic [NODE_W-1:0] parent;
    } t_node;

    localparam int NODE_BITS = $bits(t_node);

    // Finished item handed from the forest controller to the output stage
    typedef struct packed {
        logic              vld;
        logic              taken;
        logic [COST_W-1:0] cost;
    } t_fin;

    // Stream index to memory address
    function automatic logic [NODE_W-1:0] node_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[NODE_W-1:0];
    endfunction

    function automatic logic node_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(NODES);
    endfunction

endpackage

// ===== hdl/kefs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kefs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kefs_ctrl.sv =====
// Forest controller: clearing pass, root walks, union by size and station marking.
// Depends on kefs_pkg; drives the forest RAM ports of kefs_ram.
`timescale 1ns / 1ps

module kefs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beat
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [kefs_pkg::IDX_W-1:0]    i_node_a,
    input  logic [kefs_pkg::IDX_W-1:0]    i_node_b,
    input  logic [kefs_pkg::COST_W-1:0]   i_cost,
    // handoff to output stage
    output kefs_pkg::t_fin                o_fin,
    input  logic                          i_slot_free,
    // forest RAM
    output logic                          o_ram_we,
    output logic [kefs_pkg::NODE_W-1:0]   o_ram_waddr,
    output kefs_pkg::t_node               o_ram_wdata,
    output logic [kefs_pkg::NODE_W-1:0]   o_ram_raddr,
    input  kefs_pkg::t_node               i_ram_rdata
);
    import kefs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_DECIDE,
        ST_LINK2,
        ST_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [NODE_W:0]     r_clr, n_clr;
    logic                r_kind, n_kind;
    logic [NODE_W-1:0]   r_b, n_b;
    logic [COST_W-1:0]   r_cost, n_cost;
    logic [NODE_W-1:0]   r_cur, n_cur;
    logic [NODE_W-1:0]   r_ra, n_ra;
    logic [NODE_W-1:0]   r_rb, n_rb;
    t_node               r_wa, n_wa;
    t_node               r_wb, n_wb;
    logic                r_taken, n_taken;
    logic [NODE_W-1:0]   r_big, n_big;
    t_node               r_bigw, n_bigw;

    logic                in_ok;
    logic                a_small;

    assign in_ok   = node_ok(i_node_a) && ((i_kind == KIND_STATION) || node_ok(i_node_b));
    assign a_small = r_wa.size < r_wb.size;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_kind   = r_kind;
        n_b      = r_b;
        n_cost   = r_cost;
        n_cur    = r_cur;
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_wa     = r_wa;
        n_wb     = r_wb;
        n_taken  = r_taken;
        n_big    = r_big;
        n_bigw   = r_bigw;

        o_ready      = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_ra;
        o_ram_wdata  = r_wa;
        o_ram_raddr  = r_cur;
        o_fin.vld    = 1'b0;
        o_fin.taken  = r_taken;
        o_fin.cost   = r_cost;

        case (r_state)
            // Sweep every entry back to a singleton set without station
            ST_CLEAR: begin
                o_ram_we           = 1'b1;
                o_ram_waddr        = r_clr[NODE_W-1:0];
                o_ram_wdata.station = 1'b0;
                o_ram_wdata.size   = SIZE_W'(1);
                o_ram_wdata.parent = r_clr[NODE_W-1:0];
                n_clr              = r_clr + 1'b1;
                if (r_clr == (NODE_W+1)'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            // Take one beat, start the walk from node_a
            ST_IDLE: begin
                o_ready     = 1'b1;
                o_ram_raddr = node_addr(i_node_a);
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_b     = node_addr(i_node_b);
                    n_cost  = i_cost;
                    n_cur   = node_addr(i_node_a);
                    n_taken = 1'b0;
                    n_state = in_ok ? ST_FIND_A : ST_FIN;
                end
            end

            // Follow parents of node_a until an entry points to itself
            ST_FIND_A: begin
                if (i_ram_rdata.parent == r_cur) begin
                    n_ra = r_cur;
                    n_wa = i_ram_rdata;
                    if (r_kind == KIND_LINK) begin
                        n_cur       = r_b;
                        o_ram_raddr = r_b;
                        n_state     = ST_FIND_B;
                    end else begin
                        n_state = ST_DECIDE;
                    end
                end else begin
                    n_cur       = i_ram_rdata.parent;
                    o_ram_raddr = i_ram_rdata.parent;
                end
            end

            // Same walk for node_b
            ST_FIND_B: begin
                if (i_ram_rdata.parent == r_cur) begin
                    n_rb    = r_cur;
                    n_wb    = i_ram_rdata;
                    n_state = ST_DECIDE;
                end else begin
                    n_cur       = i_ram_rdata.parent;
                    o_ram_raddr = i_ram_rdata.parent;
                end
            end

            // Station mark, or first half of a union (hang the smaller root)
            ST_DECIDE: begin
                n_state = ST_FIN;
                if (r_kind == KIND_STATION) begin
                    if (!r_wa.station) begin
                        o_ram_we            = 1'b1;
                        o_ram_waddr         = r_ra;
                        o_ram_wdata         = r_wa;
                        o_ram_wdata.station = 1'b1;
                        n_taken             = 1'b1;
                    end
                end else if ((r_ra != r_rb) && !(r_wa.station && r_wb.station)) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = a_small ? r_ra : r_rb;
                    o_ram_wdata = a_small ? r_wa : r_wb;
                    o_ram_wdata.parent = a_small ? r_rb : r_ra;
                    n_big          = a_small ? r_rb : r_ra;
                    n_bigw.station = r_wa.station | r_wb.station;
                    n_bigw.size    = r_wa.size + r_wb.size;
                    n_bigw.parent  = a_small ? r_rb : r_ra;
                    n_taken        = 1'b1;
                    n_state        = ST_LINK2;
                end
            end

            // Second half of a union: grow the surviving root
            ST_LINK2: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_big;
                o_ram_wdata = r_bigw;
                n_state     = ST_FIN;
            end

            // Hand the outcome over once the output register has room
            ST_FIN: begin
                o_fin.vld = 1'b1;
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_kind  <= n_kind;
        r_b     <= n_b;
        r_cost  <= n_cost;
        r_cur   <= n_cur;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_wa    <= n_wa;
        r_wb    <= n_wb;
        r_taken <= n_taken;
        r_big   <= n_big;
        r_bigw  <= n_bigw;
    end

endmodule

// ===== hdl/kefs_total.sv =====
// Output stage: saturating running total of accepted costs and the result register.
// Depends on kefs_pkg.
`timescale 1ns / 1ps

module kefs_total (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kefs_pkg::t_fin                  i_fin,
    output logic                            o_slot_free,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [kefs_pkg::OUT_DATA_W-1:0] o_data
);
    import kefs_pkg::*;

    logic                  r_valid, n_valid;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [OUT_DATA_W-1:0] r_data, n_data;
    logic [TOTAL_W:0]      sum;

    assign o_slot_free = !r_valid || i_ready;
    assign sum         = {1'b0, r_total} + (TOTAL_W+1)'(i_fin.cost);

    // Add on acceptance, clamp at all ones
    always_comb begin
        n_valid = r_valid && !i_ready;
        n_total = r_total;
        n_data  = r_data;
        if (i_fin.vld && o_slot_free) begin
            n_valid = 1'b1;
            if (i_fin.taken) begin
                n_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
            end
            n_data = OUT_DATA_W'({n_total, i_fin.taken});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
        end else begin
            r_valid <= n_valid;
            r_total <= n_total;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/kruskal_edge_filter_with_stations.sv =====
// Kruskal edge filter with stations: union-find forest kept in one RAM.
// Depends on kefs_pkg, kefs_ram, kefs_ctrl and kefs_total.
//
// Usage:
//   Slave channel takes one candidate per beat, cost-sorted: tuser[0] is the kind
//   (0 = station offer for node_a, 1 = link node_a to node_b), tdata carries
//   node_a, node_b and cost. Master channel returns exactly one beat per input
//   beat, in order: accepted flag and the saturating running total of accepted costs.
//   Throughput: one item at a time. A link walks the parent chain of node_a, then
//   that of node_b, then decides; a taken link hangs the smaller root, then grows the
//   surviving root. A station offer walks node_a only. Union by size keeps each
//   parent-chain depth at most log2(NODES). The next beat is taken in the cycle
//   after the result is handed over. Each step of a walk is one read of the forest
//   RAM. Out-of-range nodes skip the walk and return a reject.
//   Reset: the total and the output register clear at once; then a clearing pass
//   writes every node back to a singleton set without station, with s_axis_tready low.
//   Stall: a result waits in the output register while the next beat is taken
//   and walked; the block then holds before writing its result until the
//   register is free.
`timescale 1ns / 1ps

module kruskal_edge_filter_with_stations (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // node_a [10:0], node_b [21:11], cost [61:22], zero [63:62]
    input  logic [kefs_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // kind [0]
    input  logic [0:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // accepted [0], running_total [52:1], zero [55:53]
    output logic [kefs_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import kefs_pkg::*;

    t_fin              fin;
    logic              slot_free;
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    t_node             ram_wdata;
    logic [NODE_W-1:0] ram_raddr;
    t_node             ram_rdata;

    // Forest memory: parent, set size and station flag per node
    kefs_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (NODES)
    ) u_forest (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Walk and union sequencer
    kefs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser[0]),
        .i_node_a    (i_s_axis_tdata[IDX_W-1:0]),
        .i_node_b    (i_s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_cost      (i_s_axis_tdata[2*IDX_W+COST_W-1:2*IDX_W]),
        .o_fin       (fin),
        .i_slot_free (slot_free),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Running total and result register
    kefs_total u_total (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin       (fin),
        .o_slot_free (slot_free),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule

// ===== hdl/kefs_checker.sv =====
// Port-level checks for the Kruskal edge filter with stations, bound to the top level.
// Depends on kefs_pkg.
`timescale 1ns / 1ps

module kefs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [kefs_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import kefs_pkg::*;

    logic               r_seen;
    logic [TOTAL_W-1:0] r_last;
    logic [TOTAL_W-1:0] total;

    assign total = o_m_axis_tdata[TOTAL_W:1];

    // Total of the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_seen <= 1'b1;
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_last <= total;
        end
    end

    // Result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // One item in flight: no new beat right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while an item is still in work");

    // Running total never shrinks
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_seen |-> total >= r_last)
        else $error("running total decreased");

    // A rejected item leaves the total as it was
    a_reject_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_seen && !o_m_axis_tdata[0] |-> total == r_last)
        else $error("rejected item changed the running total");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind kruskal_edge_filter_with_stations kefs_checker u_kefs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
